// ===== sv/lsd_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lsd_pkg: shared constants and types for the decimal radix sorter
// Sizes, state codes and the controller-to-datapath command bundle.
// ---------------------------------------------------------------------------
package lsd_pkg;

  localparam int MAX_ITEMS  = 64;
  localparam int MAX_DIGITS = 9;
  localparam int RADIX      = 10;
  localparam int IDX_W      = $clog2(MAX_ITEMS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int VAL_W      = 30;
  localparam int DIG_W      = 4;
  localparam int ND_W       = 4;
  localparam int TDATA_W    = 32;

  // 1 / 10 as a 35-bit fixed-point reciprocal, exact for 32-bit dividends
  localparam logic [31:0] RECIP10  = 32'hCCCC_CCCD;
  localparam int          RECIP_SH = 35;

  // controller states
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_PINIT  = 4'd1;
  localparam logic [3:0] ST_CRD    = 4'd2;
  localparam logic [3:0] ST_CMUL   = 4'd3;
  localparam logic [3:0] ST_CACC   = 4'd4;
  localparam logic [3:0] ST_PFX    = 4'd5;
  localparam logic [3:0] ST_SRD    = 4'd6;
  localparam logic [3:0] ST_SMUL   = 4'd7;
  localparam logic [3:0] ST_SACC   = 4'd8;
  localparam logic [3:0] ST_ORD    = 4'd9;
  localparam logic [3:0] ST_OWAIT  = 4'd10;

  // one stored entry: the value and its running quotient by 10^pass
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [VAL_W-1:0] quo;
  } entry_t;

  typedef struct packed {
    logic             load_we;   // write incoming value to bank A
    logic [IDX_W-1:0] addr;      // read address, load write address
    logic             src_sel;   // 0: bank A is source, 1: bank B
    logic             cnt_clr;   // clear digit counts and running sum
    logic             cnt_inc;   // bump count of current digit
    logic             scat_we;   // scatter current entry to other bank
    logic             pfx_en;    // one step of the exclusive prefix sum
    logic [DIG_W-1:0] pfx_idx;
  } dp_cmd_t;

endpackage

// ===== sv/lsd_dp.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lsd_dp: sorter datapath
// Two ping-pong banks, divide-by-ten stage, digit counters and prefix sum.
// ---------------------------------------------------------------------------
module lsd_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lsd_pkg::dp_cmd_t             cmd_i,
  input  logic [lsd_pkg::VAL_W-1:0]    load_value_i,
  output logic [lsd_pkg::VAL_W-1:0]    out_value_o
);

  lsd_pkg::entry_t mem_a [lsd_pkg::MAX_ITEMS];
  lsd_pkg::entry_t mem_b [lsd_pkg::MAX_ITEMS];
  lsd_pkg::entry_t a_rd_q, b_rd_q, rd_ent;

  logic [lsd_pkg::CNT_W-1:0] cnt_q [lsd_pkg::RADIX];
  logic [lsd_pkg::CNT_W-1:0] run_q;
  logic [lsd_pkg::VAL_W-1:0] q10_q;
  logic [61:0]               prod;
  logic [lsd_pkg::VAL_W-1:0] rem;
  logic [lsd_pkg::DIG_W-1:0] dg;
  logic [lsd_pkg::IDX_W-1:0] wr_idx;
  lsd_pkg::entry_t           scat_ent;

  // registered reads of both banks
  always_ff @(posedge clk_i) begin
    a_rd_q <= mem_a[cmd_i.addr];
    b_rd_q <= mem_b[cmd_i.addr];
  end

  assign rd_ent      = cmd_i.src_sel ? b_rd_q : a_rd_q;
  assign out_value_o = rd_ent.value;

  // quotient by ten through the reciprocal, registered
  assign prod = 62'(rd_ent.quo) * 62'(lsd_pkg::RECIP10);

  always_ff @(posedge clk_i) begin
    q10_q <= lsd_pkg::VAL_W'(prod[61:lsd_pkg::RECIP_SH]);
  end

  // low digit = q - 10 * (q / 10)
  assign rem = rd_ent.quo - ((q10_q << 3) + (q10_q << 1));
  assign dg  = rem[lsd_pkg::DIG_W-1:0];

  assign wr_idx         = cnt_q[dg][lsd_pkg::IDX_W-1:0];
  assign scat_ent.value = rd_ent.value;
  assign scat_ent.quo   = q10_q;

  // bank writes: load goes to A, scatter goes to the non-source bank
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we) begin
      mem_a[cmd_i.addr] <= '{value: load_value_i, quo: load_value_i};
    end else if (cmd_i.scat_we && cmd_i.src_sel) begin
      mem_a[wr_idx] <= scat_ent;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scat_we && !cmd_i.src_sel) begin
      mem_b[wr_idx] <= scat_ent;
    end
  end

  // digit counts, then offsets after the prefix sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < lsd_pkg::RADIX; i++) cnt_q[i] <= '0;
      run_q <= '0;
    end else if (cmd_i.cnt_clr) begin
      for (int i = 0; i < lsd_pkg::RADIX; i++) cnt_q[i] <= '0;
      run_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_q[dg] <= cnt_q[dg] + 1'b1;
    end else if (cmd_i.pfx_en) begin
      cnt_q[cmd_i.pfx_idx] <= run_q;
      run_q <= run_q + cnt_q[cmd_i.pfx_idx];
    end
  end

endmodule

// ===== sv/lsd_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lsd_ctrl: sorter controller
// Sequences load, per-digit count / prefix / scatter passes and readout.
// ---------------------------------------------------------------------------
module lsd_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_last_i,
  output logic                         in_ready_o,
  output logic                         out_valid_o,
  output logic                         out_last_o,
  output logic                         out_drop_o,
  input  logic                         out_ready_i,
  input  logic                         cfg_we_i,
  input  logic [lsd_pkg::ND_W-1:0]     cfg_data_i,
  output lsd_pkg::dp_cmd_t             cmd_o
);

  logic [3:0]                state_q, state_d;
  logic [lsd_pkg::CNT_W-1:0] n_q, n_d, idx_q, idx_d;
  logic                      ovf_q, ovf_d, src_q, src_d;
  logic [lsd_pkg::ND_W-1:0]  nd_q, pass_q, pass_d, passes_q, passes_d;
  logic [lsd_pkg::DIG_W-1:0] dig_q, dig_d;
  logic                      idx_end, in_acc, out_acc;

  assign idx_end = (idx_q + 1'b1) == n_q;
  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  assign in_ready_o  = (state_q == lsd_pkg::ST_IDLE);
  assign out_valid_o = (state_q == lsd_pkg::ST_OWAIT);
  assign out_last_o  = idx_end;
  assign out_drop_o  = ovf_q;

  // digit-count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nd_q <= lsd_pkg::ND_W'(1);
    end else if (cfg_we_i) begin
      nd_q <= cfg_data_i;
    end
  end

  // next state and commands
  always_comb begin
    state_d  = state_q;
    n_d      = n_q;
    idx_d    = idx_q;
    ovf_d    = ovf_q;
    src_d    = src_q;
    pass_d   = pass_q;
    passes_d = passes_q;
    dig_d    = dig_q;
    cmd_o         = '0;
    cmd_o.src_sel = src_q;
    cmd_o.addr    = idx_q[lsd_pkg::IDX_W-1:0];
    cmd_o.pfx_idx = dig_q;
    case (state_q)
      lsd_pkg::ST_IDLE: begin
        cmd_o.addr = n_q[lsd_pkg::IDX_W-1:0];
        if (in_acc) begin
          if (n_q < lsd_pkg::CNT_W'(lsd_pkg::MAX_ITEMS)) begin
            cmd_o.load_we = 1'b1;
            n_d = n_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (in_last_i) begin
            passes_d = (nd_q > lsd_pkg::ND_W'(lsd_pkg::MAX_DIGITS)) ?
                       lsd_pkg::ND_W'(lsd_pkg::MAX_DIGITS) : nd_q;
            src_d  = 1'b0;
            pass_d = '0;
            idx_d  = '0;
            state_d = (passes_d == '0) ? lsd_pkg::ST_ORD : lsd_pkg::ST_PINIT;
          end
        end
      end
      lsd_pkg::ST_PINIT: begin
        cmd_o.cnt_clr = 1'b1;
        idx_d   = '0;
        state_d = lsd_pkg::ST_CRD;
      end
      lsd_pkg::ST_CRD:  state_d = lsd_pkg::ST_CMUL;
      lsd_pkg::ST_CMUL: state_d = lsd_pkg::ST_CACC;
      lsd_pkg::ST_CACC: begin
        cmd_o.cnt_inc = 1'b1;
        idx_d = idx_q + 1'b1;
        if (idx_end) begin
          dig_d   = '0;
          state_d = lsd_pkg::ST_PFX;
        end else begin
          state_d = lsd_pkg::ST_CRD;
        end
      end
      lsd_pkg::ST_PFX: begin
        cmd_o.pfx_en = 1'b1;
        dig_d = dig_q + 1'b1;
        if (dig_q == lsd_pkg::DIG_W'(lsd_pkg::RADIX - 1)) begin
          idx_d   = '0;
          state_d = lsd_pkg::ST_SRD;
        end
      end
      lsd_pkg::ST_SRD:  state_d = lsd_pkg::ST_SMUL;
      lsd_pkg::ST_SMUL: state_d = lsd_pkg::ST_SACC;
      lsd_pkg::ST_SACC: begin
        cmd_o.scat_we = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        idx_d = idx_q + 1'b1;
        if (idx_end) begin
          src_d  = !src_q;
          pass_d = pass_q + 1'b1;
          idx_d  = '0;
          state_d = ((pass_q + 1'b1) == passes_q) ? lsd_pkg::ST_ORD : lsd_pkg::ST_PINIT;
        end else begin
          state_d = lsd_pkg::ST_SRD;
        end
      end
      lsd_pkg::ST_ORD: state_d = lsd_pkg::ST_OWAIT;
      lsd_pkg::ST_OWAIT: begin
        if (out_acc) begin
          if (idx_end) begin
            n_d     = '0;
            ovf_d   = 1'b0;
            state_d = lsd_pkg::ST_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = lsd_pkg::ST_ORD;
          end
        end
      end
      default: state_d = lsd_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= lsd_pkg::ST_IDLE;
      n_q      <= '0;
      idx_q    <= '0;
      ovf_q    <= 1'b0;
      src_q    <= 1'b0;
      pass_q   <= '0;
      passes_q <= '0;
      dig_q    <= '0;
    end else begin
      state_q  <= state_d;
      n_q      <= n_d;
      idx_q    <= idx_d;
      ovf_q    <= ovf_d;
      src_q    <= src_d;
      pass_q   <= pass_d;
      passes_q <= passes_d;
      dig_q    <= dig_d;
    end
  end

endmodule

// ===== sv/lsd_decimal_radix_sorter.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lsd_decimal_radix_sorter: base-10 LSD radix sorter, up to 64 values
// Loads one value per transaction, sorts on the tlast transaction, streams out.
// ---------------------------------------------------------------------------
// Loading: one value per cycle while idle; the set is closed by tlast.
// Sort: each digit pass clears the counts, counts the digit of all n stored
//   values, takes a ten-step prefix sum and scatters all n to the other bank,
//   all through the shared read / divide-by-ten path of one bank port.
// Output: each value is read from bank RAM, then offered and held until taken.
// Reset clears control and digit counts at once; banks need no clearing.
module lsd_decimal_radix_sorter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [lsd_pkg::TDATA_W-1:0] s_axis_tdata,   // [29:0] value
  input  logic                        s_axis_tlast,   // last_item
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [lsd_pkg::TDATA_W-1:0] m_axis_tdata,   // [29:0] sorted_value
  output logic                        m_axis_tlast,   // last_out
  output logic                        m_axis_tuser,   // dropped
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [lsd_pkg::ND_W-1:0]    cfg_data        // num_digits
);

  lsd_pkg::dp_cmd_t           cmd;
  logic [lsd_pkg::VAL_W-1:0]  out_value;

  assign cfg_ready = 1'b1;

  lsd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_last_o  (m_axis_tlast),
    .out_drop_o  (m_axis_tuser),
    .out_ready_i (m_axis_tready),
    .cfg_we_i    (cfg_valid && cfg_ready),
    .cfg_data_i  (cfg_data),
    .cmd_o       (cmd)
  );

  lsd_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .load_value_i (s_axis_tdata[lsd_pkg::VAL_W-1:0]),
    .out_value_o  (out_value)
  );

  assign m_axis_tdata = lsd_pkg::TDATA_W'(out_value);

endmodule

// ===== sv/lsd_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lsd_checker: port-level checks for the radix sorter
// Load and readout phases never overlap; a run ends cleanly.
// ---------------------------------------------------------------------------
module lsd_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic s_axis_tlast,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic m_axis_tlast
);

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // never loading while results are offered
  a_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("load and readout overlap");

  // closing a set stops loading
  a_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input taken after end of set");

  // final result ends the run
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
    else $error("result after end of run");

endmodule

bind lsd_decimal_radix_sorter lsd_checker u_lsd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tlast  (m_axis_tlast)
);
